>>> rtl/core/hrls_pkg.sv
package hrls_pkg;

    localparam int PIX_W    = 8;
    localparam int LIMIT_W  = 6;
    localparam int CNT_W    = 7;
    localparam int QDEPTH   = 4;
    localparam int QPTR_W   = 2;

    localparam logic [PIX_W-1:0]   PIX_BLACK       = 8'h00;
    localparam logic [PIX_W-1:0]   PIX_WHITE       = 8'hFF;
    localparam logic [LIMIT_W-1:0] GAP_LIMIT_RESET = 6'd30;

    // One burst for the output side: a run of count pixels of one color,
    // optionally followed by a single black pixel.
    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             white;
        logic             tail;
        logic             row;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

>>> rtl/core/hrls_front.sv
module hrls_front #(
    parameter int MAX_GAP = 63
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [hrls_pkg::LIMIT_W-1:0]  cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [hrls_pkg::PIX_W-1:0]    pixel_in,
    input  logic                          row_end,
    input  hrls_pkg::q_stat_t             q_stat,
    output logic                          push,
    output hrls_pkg::cmd_t                push_cmd
);

    localparam logic [7:0] MAX_GAP_V = 8'(MAX_GAP);

    logic [hrls_pkg::LIMIT_W-1:0] gap_limit_reg;
    logic                         black_seen_reg, black_seen_next;
    logic [hrls_pkg::CNT_W-1:0]   gap_count_reg, gap_count_next;
    logic [hrls_pkg::LIMIT_W-1:0] limit;
    logic [hrls_pkg::CNT_W-1:0]   gap_inc;
    logic                         accept;
    logic                         push_want;
    hrls_pkg::cmd_t               cmd;

    assign cfg_ready = 1'b1;
    assign in_stall  = q_stat.full;
    assign accept    = in_valid && !q_stat.full;

    // The limit in force is the smaller of the register and MAX_GAP.
    assign limit   = ({2'b00, gap_limit_reg} > MAX_GAP_V) ? MAX_GAP_V[hrls_pkg::LIMIT_W-1:0]
                                                         : gap_limit_reg;
    assign gap_inc = gap_count_reg + 7'd1;

    always_comb
    begin
        cmd             = '0;
        push_want       = 1'b0;
        black_seen_next = black_seen_reg;
        gap_count_next  = gap_count_reg;
        priority if (pixel_in == hrls_pkg::PIX_BLACK)
        begin
            cmd.count       = gap_count_reg;
            cmd.white       = gap_count_reg > {1'b0, limit};
            cmd.tail        = 1'b1;
            push_want       = 1'b1;
            black_seen_next = 1'b1;
            gap_count_next  = '0;
        end
        else if (!black_seen_reg)
        begin
            cmd.count = 7'd1;
            cmd.white = 1'b1;
            push_want = 1'b1;
        end
        else if ((gap_inc > {1'b0, limit}) || row_end)
        begin
            cmd.count       = gap_inc;
            cmd.white       = 1'b1;
            push_want       = 1'b1;
            black_seen_next = 1'b0;
            gap_count_next  = '0;
        end
        else
        begin
            gap_count_next = gap_inc;
        end
        if (row_end)
        begin
            black_seen_next = 1'b0;
            gap_count_next  = '0;
        end
        cmd.row = row_end;
    end

    assign push     = accept && push_want;
    assign push_cmd = cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_limit_reg  <= hrls_pkg::GAP_LIMIT_RESET;
            black_seen_reg <= 1'b0;
            gap_count_reg  <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                gap_limit_reg <= cfg_data;
            end
            if (accept)
            begin
                black_seen_reg <= black_seen_next;
                gap_count_reg  <= gap_count_next;
            end
        end
    end

`ifndef SYNTH
    a_gap_needs_black : assert property (@(posedge clk) disable iff (!rst_n)
        !black_seen_reg |-> gap_count_reg == '0)
        else $error("held gap without a preceding black pixel");
    a_gap_bounded : assert property (@(posedge clk) disable iff (!rst_n)
        gap_count_reg < 7'd64)
        else $error("held gap count out of range");
`endif

endmodule

>>> rtl/core/hrls_queue.sv
module hrls_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  hrls_pkg::cmd_t    push_cmd,
    input  logic              pop,
    output hrls_pkg::cmd_t    head,
    output hrls_pkg::q_stat_t q_stat
);

    hrls_pkg::cmd_t                entries_reg [hrls_pkg::QDEPTH];
    logic [hrls_pkg::QPTR_W-1:0]   wr_ptr_reg;
    logic [hrls_pkg::QPTR_W-1:0]   rd_ptr_reg;
    logic [hrls_pkg::QPTR_W:0]     fill_reg;

    assign head         = entries_reg[rd_ptr_reg];
    assign q_stat.full  = fill_reg == (hrls_pkg::QPTR_W+1)'(hrls_pkg::QDEPTH);
    assign q_stat.empty = fill_reg == '0;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

`ifndef SYNTH
    a_no_overflow : assert property (@(posedge clk) disable iff (!rst_n)
        !(push && q_stat.full) && !(pop && q_stat.empty))
        else $error("queue overflow or underflow");
`endif

endmodule

>>> rtl/core/hrls_back.sv
module hrls_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  hrls_pkg::cmd_t              head,
    input  hrls_pkg::q_stat_t           q_stat,
    output logic                        pop,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [hrls_pkg::PIX_W-1:0]  pixel_out,
    output logic                        burst_last,
    output logic                        row_last
);

    logic [hrls_pkg::CNT_W-1:0] sent_reg, sent_next;
    logic                       out_valid_reg;
    logic [hrls_pkg::PIX_W-1:0] pixel_out_reg;
    logic                       burst_last_reg;
    logic                       row_last_reg;
    logic                       in_run;
    logic                       fin;
    logic [hrls_pkg::PIX_W-1:0] pix;
    logic                       adv;
    logic                       take;

    assign in_run = sent_reg < head.count;
    assign adv    = !out_valid_reg || !out_stall;
    assign take   = adv && !q_stat.empty;

    always_comb
    begin
        if (in_run)
        begin
            pix = head.white ? hrls_pkg::PIX_WHITE : hrls_pkg::PIX_BLACK;
            fin = ((sent_reg + 7'd1) == head.count) && !head.tail;
        end
        else
        begin
            pix = hrls_pkg::PIX_BLACK;
            fin = 1'b1;
        end
        sent_next = sent_reg;
        if (take)
        begin
            sent_next = fin ? '0 : sent_reg + 7'd1;
        end
    end

    assign pop = take && fin;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sent_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sent_reg <= sent_next;
            if (adv)
            begin
                out_valid_reg <= !q_stat.empty;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            pixel_out_reg  <= pix;
            burst_last_reg <= fin;
            row_last_reg   <= fin && head.row;
        end
    end

    assign out_valid  = out_valid_reg;
    assign pixel_out  = pixel_out_reg;
    assign burst_last = burst_last_reg;
    assign row_last   = row_last_reg;

`ifndef SYNTH
    a_burst_has_cmd : assert property (@(posedge clk) disable iff (!rst_n)
        (sent_reg != '0) |-> !q_stat.empty)
        else $error("burst in progress without a queued command");
`endif

endmodule

>>> rtl/core/horizontal_run_length_smoothing_core.sv
// Horizontal run-length smoothing of a grayscale pixel stream. A zero pixel
// is black and any other value is white; a white gap of at most gap_limit
// pixels (capped at MAX_GAP) between two black pixels of one row is filled
// black, while longer, leading and trailing gaps stay white. Output pixels are
// 0 or 255 in input order, with burst_last on the last result of each item and
// row_last on the final pixel of a row. An item that only extends a pending
// gap produces no result at once; the held pixels come out later as a burst.
// The front classifies one item per cycle unless the queue is full, and places
// a burst command in a four-entry queue; the back expands each command at one
// pixel per cycle into the output register unless out_stall is high. A row
// yields exactly as many pixels as it takes, so the sustained rate is one item
// per cycle while out_stall is low, set by the single-pixel output port.
// An item that releases a burst of n pixels (n is at most 64) holds the back
// while the front keeps taking items until the queue fills. gap_limit is
// written through the cfg port, which is always ready.
module horizontal_run_length_smoothing_core #(
    parameter int MAX_GAP = 63
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [hrls_pkg::LIMIT_W-1:0]  cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [hrls_pkg::PIX_W-1:0]    pixel_in,
    input  logic                          row_end,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [hrls_pkg::PIX_W-1:0]    pixel_out,
    output logic                          burst_last,
    output logic                          row_last
);

    hrls_pkg::q_stat_t q_stat;
    hrls_pkg::cmd_t    push_cmd;
    hrls_pkg::cmd_t    head;
    logic              push;
    logic              pop;

    // Front: gap bookkeeping and burst classification.
    hrls_front #(
        .MAX_GAP (MAX_GAP)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .pixel_in  (pixel_in),
        .row_end   (row_end),
        .q_stat    (q_stat),
        .push      (push),
        .push_cmd  (push_cmd)
    );

    // Command queue that decouples the two sides.
    hrls_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .q_stat   (q_stat)
    );

    // Back: expands each command into output pixels.
    hrls_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .q_stat     (q_stat),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .pixel_out  (pixel_out),
        .burst_last (burst_last),
        .row_last   (row_last)
    );

endmodule

>>> tb/horizontal_run_length_smoothing_core_test.sv
`timescale 1ns / 100ps

module horizontal_run_length_smoothing_core_test;

    // The block is built with its default gap cap, and the predictor uses the same cap.
    localparam int GAP_CAP      = 63;
    // Each item can release at most this many pixels.
    localparam int BURST_MAX    = 64;
    localparam int RANDOM_ITEMS = 400;
    localparam int PHASE_ITEMS  = 50;
    // Cycles to let pass after the last expected pixel before a register write or the
    // end of the run. The first pixel of an item passes through the command queue and
    // the output register, so this margin covers an item that is still in the command queue.
    localparam int SETTLE_CYCLES = 8;
    // Length of the one long receiver hold-off that fills the command queue.
    localparam int HOLD_CYCLES  = 300;
    // Cycles with no accepted item on any channel before the run is called hung. The
    // longest quiet stretch in a correct run is the receiver hold-off plus a short
    // random stall streak, and this limit is several times that.
    localparam int STUCK_LIMIT  = 3000;
    localparam int ERR_PRINT_MAX = 100;

    typedef enum logic {
        ROW_PIXEL,
        ROW_CONFIG
    } row_kind_t;

    // One row of the directed table. A config row carries the new gap limit in pixel.
    // Where typed is set, the expected output is count pixels of one color, and row
    // marks whether the last of them closes the image row.
    typedef struct packed {
        row_kind_t                  kind;
        logic [hrls_pkg::PIX_W-1:0] pixel;
        logic                       last;
        logic                       typed;
        logic [hrls_pkg::CNT_W-1:0] count;
        logic                       white;
        logic                       row;
    } stim_row_t;

    typedef struct packed {
        logic [hrls_pkg::PIX_W-1:0] pixel;
        logic                       burst_last;
        logic                       row_last;
    } out_pixel_t;

    localparam int DIRECTED_ROWS = 28;

    // The directed part starts from reset, where the gap limit is 30. It covers leading
    // white pixels, a gap that gets filled, a trailing gap released at the row end,
    // black and white pixels that end a row, a zero gap limit, a gap that runs past
    // the limit, and a gap that is still held when the limit is lowered below its
    // length.
    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        '{ROW_PIXEL,  8'hFF, 1'b0, 1'b1, 7'd1, 1'b1, 1'b0},
        '{ROW_PIXEL,  8'h01, 1'b0, 1'b1, 7'd1, 1'b1, 1'b0},
        '{ROW_PIXEL,  8'h80, 1'b0, 1'b1, 7'd1, 1'b1, 1'b0},
        '{ROW_PIXEL,  8'h00, 1'b0, 1'b1, 7'd1, 1'b0, 1'b0},
        '{ROW_PIXEL,  8'h55, 1'b0, 1'b1, 7'd0, 1'b0, 1'b0},
        '{ROW_PIXEL,  8'hAA, 1'b0, 1'b1, 7'd0, 1'b0, 1'b0},
        '{ROW_PIXEL,  8'h00, 1'b0, 1'b1, 7'd3, 1'b0, 1'b0},
        '{ROW_PIXEL,  8'h7F, 1'b0, 1'b1, 7'd0, 1'b0, 1'b0},
        '{ROW_PIXEL,  8'hFE, 1'b1, 1'b1, 7'd2, 1'b1, 1'b1},
        '{ROW_PIXEL,  8'h00, 1'b1, 1'b1, 7'd1, 1'b0, 1'b1},
        '{ROW_PIXEL,  8'hFF, 1'b1, 1'b1, 7'd1, 1'b1, 1'b1},
        '{ROW_CONFIG, 8'd0,  1'b0, 1'b0, 7'd0, 1'b0, 1'b0},
        '{ROW_PIXEL,  8'h00, 1'b0, 1'b1, 7'd1, 1'b0, 1'b0},
        '{ROW_PIXEL,  8'hFF, 1'b0, 1'b1, 7'd1, 1'b1, 1'b0},
        '{ROW_PIXEL,  8'h00, 1'b0, 1'b1, 7'd1, 1'b0, 1'b0},
        '{ROW_PIXEL,  8'h00, 1'b1, 1'b1, 7'd1, 1'b0, 1'b1},
        '{ROW_CONFIG, 8'd2,  1'b0, 1'b0, 7'd0, 1'b0, 1'b0},
        '{ROW_PIXEL,  8'h00, 1'b0, 1'b1, 7'd1, 1'b0, 1'b0},
        '{ROW_PIXEL,  8'h40, 1'b0, 1'b1, 7'd0, 1'b0, 1'b0},
        '{ROW_PIXEL,  8'h20, 1'b0, 1'b1, 7'd0, 1'b0, 1'b0},
        '{ROW_PIXEL,  8'h10, 1'b0, 1'b1, 7'd3, 1'b1, 1'b0},
        '{ROW_PIXEL,  8'h08, 1'b0, 1'b1, 7'd1, 1'b1, 1'b0},
        '{ROW_PIXEL,  8'h00, 1'b0, 1'b1, 7'd1, 1'b0, 1'b0},
        '{ROW_PIXEL,  8'h04, 1'b0, 1'b1, 7'd0, 1'b0, 1'b0},
        '{ROW_PIXEL,  8'h02, 1'b0, 1'b1, 7'd0, 1'b0, 1'b0},
        '{ROW_CONFIG, 8'd1,  1'b0, 1'b0, 7'd0, 1'b0, 1'b0},
        '{ROW_PIXEL,  8'h00, 1'b0, 1'b0, 7'd0, 1'b0, 1'b0},
        '{ROW_PIXEL,  8'h00, 1'b1, 1'b1, 7'd1, 1'b0, 1'b1}
    };

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [hrls_pkg::LIMIT_W-1:0]   cfg_data  = '0;
    logic                           in_valid  = 1'b0;
    logic                           in_stall;
    logic [hrls_pkg::PIX_W-1:0]     pixel_in  = '0;
    logic                           row_end   = 1'b0;
    logic                           out_valid;
    logic                           out_stall = 1'b0;
    logic [hrls_pkg::PIX_W-1:0]     pixel_out;
    logic                           burst_last;
    logic                           row_last;

    // The predictor's own copy of the block state and its register.
    logic [hrls_pkg::LIMIT_W-1:0]   gap_limit_now  = hrls_pkg::GAP_LIMIT_RESET;
    logic                           gap_open       = 1'b0;
    logic [hrls_pkg::CNT_W-1:0]     held_whites    = '0;

    out_pixel_t           released_pixels [$];
    out_pixel_t           expected_pixels [$];

    // The expectation that the directed table gives for the item now on the input.
    bit                   cur_typed = 0;
    int                   cur_count = 0;
    bit                   cur_white = 0;
    bit                   cur_row   = 0;

    int                   in_idle_pct  = 30;
    int                   out_idle_pct = 30;
    int                   hold_request = 0;
    int                   items_sent   = 0;
    int                   error_count  = 0;

    horizontal_run_length_smoothing_core #(
        .MAX_GAP(GAP_CAP)
    ) DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .pixel_in   (pixel_in),
        .row_end    (row_end),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .pixel_out  (pixel_out),
        .burst_last (burst_last),
        .row_last   (row_last)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Appends a run of one color to the pixels released by the current item.
    function automatic void release_run(input int count,
                                        input logic [hrls_pkg::PIX_W-1:0] color);
        out_pixel_t px;
        px.pixel      = color;
        px.burst_last = 1'b0;
        px.row_last   = 1'b0;
        for (int i = 0; i < count && released_pixels.size() < BURST_MAX; i++)
            released_pixels = {released_pixels, px};
    endfunction

    // Smooths one accepted item: updates the held gap and fills released_pixels with
    // the pixels that the item lets out, in output order.
    function automatic void smooth_item(input logic [hrls_pkg::PIX_W-1:0] pix,
                                        input logic last);
        int         limit;
        out_pixel_t px;
        limit = (gap_limit_now > GAP_CAP) ? GAP_CAP : int'(gap_limit_now);
        released_pixels.delete();
        if (pix == hrls_pkg::PIX_BLACK)
        begin
            // A held gap closed by black is filled only if it still fits the limit.
            if (gap_open && held_whites != 0)
                release_run(held_whites, (int'(held_whites) <= limit) ?
                            hrls_pkg::PIX_BLACK : hrls_pkg::PIX_WHITE);
            release_run(1, hrls_pkg::PIX_BLACK);
            gap_open    = 1'b1;
            held_whites = '0;
        end
        else if (!gap_open)
        begin
            release_run(1, hrls_pkg::PIX_WHITE);
        end
        else if (int'(held_whites) + 1 > limit)
        begin
            // The gap has grown past the limit, so it can never be filled.
            release_run(int'(held_whites) + 1, hrls_pkg::PIX_WHITE);
            gap_open    = 1'b0;
            held_whites = '0;
        end
        else
        begin
            held_whites = held_whites + 1'b1;
        end
        if (last)
        begin
            // A gap still open at the row end touches the edge and stays white.
            if (held_whites != 0)
                release_run(held_whites, hrls_pkg::PIX_WHITE);
            gap_open    = 1'b0;
            held_whites = '0;
        end
        if (released_pixels.size() != 0)
        begin
            px            = released_pixels[released_pixels.size() - 1];
            px.burst_last = 1'b1;
            px.row_last   = last;
            released_pixels[released_pixels.size() - 1] = px;
        end
    endfunction

    function automatic void flag_mismatch(input string field,
                                          input logic [hrls_pkg::PIX_W-1:0] want,
                                          input logic [hrls_pkg::PIX_W-1:0] got);
        error_count++;
        if (error_count <= ERR_PRINT_MAX)
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    endfunction

    // Everything is sampled at the rising edge, while the testbench changes its inputs
    // only at the falling edge. A register write is taken into the predictor first,
    // then an accepted item, then an accepted output pixel.
    always @(posedge clk)
    begin
        out_pixel_t want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                gap_limit_now = cfg_data;
            if (in_valid && !in_stall)
            begin
                smooth_item(pixel_in, row_end);
                if (cur_typed)
                begin
                    // Rows of the table that spell out their result replace the
                    // predicted pixels, while the predictor still tracks the state.
                    for (int i = 0; i < cur_count; i++)
                    begin
                        want.pixel      = cur_white ? hrls_pkg::PIX_WHITE
                                                    : hrls_pkg::PIX_BLACK;
                        want.burst_last = (i == cur_count - 1);
                        want.row_last   = (i == cur_count - 1) && cur_row;
                        expected_pixels = {expected_pixels, want};
                    end
                end
                else
                begin
                    expected_pixels = {expected_pixels, released_pixels};
                end
            end
            if (out_valid && !out_stall)
            begin
                if (expected_pixels.size() == 0)
                begin
                    error_count++;
                    if (error_count <= ERR_PRINT_MAX)
                        $display("%0t: unexpected pixel, expected none, actual %0d",
                                 $time, pixel_out);
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (pixel_out !== want.pixel)
                        flag_mismatch("pixel_out", want.pixel, pixel_out);
                    if (burst_last !== want.burst_last)
                        flag_mismatch("burst_last", want.burst_last, burst_last);
                    if (row_last !== want.row_last)
                        flag_mismatch("row_last", want.row_last, row_last);
                end
            end
        end
    end

    // The receiver stalls at random, except during the one long hold-off that the
    // stimulus asks for, which is counted down here.
    initial
    begin
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_request != 0)
            begin
                hold_left    = HOLD_CYCLES;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
            begin
                out_stall <= ($urandom_range(99) < out_idle_pct);
            end
        end
    end

    // Ends the run if no item moves on any channel for too long.
    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STUCK_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall)
                    || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Offers one item, starting at a falling edge, and returns at the falling edge
    // after it has been taken. The table's expectation, if any, travels with it.
    task automatic send_item(input logic [hrls_pkg::PIX_W-1:0] pix, input logic last,
                             input bit typed, input int count, input bit white,
                             input bit row);
        if ($urandom_range(99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
            while ($urandom_range(99) < in_idle_pct)
                @(negedge clk);
        end
        in_valid  <= 1'b1;
        pixel_in  <= pix;
        row_end   <= last;
        cur_typed = typed;
        cur_count = count;
        cur_white = white;
        cur_row   = row;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
        @(negedge clk);
    endtask

    // Stops the input, waits until every expected pixel is out and the block has
    // settled, and only then writes the new gap limit.
    task automatic write_gap_limit(input logic [hrls_pkg::LIMIT_W-1:0] limit);
        in_valid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= limit;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [hrls_pkg::PIX_W-1:0] any_white();
        logic [31:0] r;
        r = $urandom_range(1, 255);
        return r[hrls_pkg::PIX_W-1:0];
    endfunction

    // Sends one image row. Most rows are shaped: black runs separated by white gaps
    // whose lengths sit at, just below or just above the limit, or are random, with an
    // optional leading gap and a gap that may be left open at the row end. One row in
    // eight is noise: random black and white pixels with row ends wherever they fall.
    task automatic send_random_row(input int limit);
        logic [hrls_pkg::PIX_W-1:0] row_pix [$];
        int                         runs;
        int                         gap;
        logic [hrls_pkg::PIX_W-1:0] pix;
        if ($urandom_range(7) == 0)
        begin
            repeat ($urandom_range(1, 12))
            begin
                pix = $urandom_range(1) ? hrls_pkg::PIX_BLACK : any_white();
                send_item(pix, ($urandom_range(7) == 0), 0, 0, 0, 0);
            end
        end
        else
        begin
            repeat ($urandom_range(0, 3)) row_pix = {row_pix, any_white()};
            runs = (limit > 20) ? $urandom_range(1, 2) : $urandom_range(1, 4);
            repeat (runs)
            begin
                repeat ($urandom_range(1, 2)) row_pix = {row_pix, hrls_pkg::PIX_BLACK};
                case ($urandom_range(3))
                    0:       gap = limit;
                    1:       gap = limit + 1;
                    2:       gap = (limit > 0) ? limit - 1 : 0;
                    default: gap = $urandom_range(0, limit + 2);
                endcase
                repeat (gap) row_pix = {row_pix, any_white()};
            end
            if ($urandom_range(1))
                row_pix = {row_pix, hrls_pkg::PIX_BLACK};
            foreach (row_pix[i])
                send_item(row_pix[i], (i == row_pix.size() - 1), 0, 0, 0, 0);
        end
    endtask

    initial
    begin
        int random_start;
        int phase_start;
        int phase;
        int limit;

        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_CONFIG)
                write_gap_limit(directed_rows[i].pixel[hrls_pkg::LIMIT_W-1:0]);
            else
                send_item(directed_rows[i].pixel, directed_rows[i].last,
                          directed_rows[i].typed, directed_rows[i].count,
                          directed_rows[i].white, directed_rows[i].row);
        end

        // Random phases, each under its own gap limit. The first runs at the widest
        // limit, the second at zero, and the rest mostly at small limits. The third
        // phase runs with no idling on either side, and the fifth starts with the
        // long receiver hold-off while the sender keeps offering items.
        random_start = items_sent;
        phase = 0;
        while (items_sent - random_start < RANDOM_ITEMS)
        begin
            case (phase)
                0:       limit = GAP_CAP;
                1:       limit = 0;
                5:       limit = $urandom_range(20, 40);
                default: limit = $urandom_range(1, 12);
            endcase
            write_gap_limit(limit[hrls_pkg::LIMIT_W-1:0]);
            in_idle_pct  = (phase == 2) ? 0 : 30;
            out_idle_pct = (phase == 2) ? 0 : 30;
            if (phase == 4)
                hold_request = 1;
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS)
                send_random_row(limit);
            phase++;
        end

        in_valid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/hrls_pkg.sv
rtl/core/hrls_front.sv
rtl/core/hrls_queue.sv
rtl/core/hrls_back.sv
rtl/core/horizontal_run_length_smoothing_core.sv
tb/horizontal_run_length_smoothing_core_test.sv
